// File: rtl/bmf_pkg.sv
// shared types, constants and codes of the 5x5 box mean filter
package bmf_pkg;

   // default frame limits
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // configuration registers
   localparam int CFG_W = 9;
   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

   // pixel and window geometry
   localparam int PIX_W     = 8;
   localparam int BOX_N     = 5;
   localparam int BOX_HALF  = 2;
   localparam int LINE_ROWS = 4;

   // column sum of five pixels and box sum of 25 pixels
   localparam int COL_SUM_W = 11;
   localparam int BOX_SUM_W = 13;

   // divide by 25 as multiply by reciprocal, exact for sums below 43690
   localparam int DIV_SHIFT = 17;
   localparam logic [BOX_SUM_W-1:0] DIV_MULT = 13'd5243;
   localparam int PROD_W = 2 * BOX_SUM_W;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [BOX_N-1:0][PIX_W-1:0] column_type;

   typedef struct packed {
      op_type           op;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic             last;
   } rsp_type;

   // per-transfer control from the sequencer to the datapath
   typedef struct packed {
      logic       push;
      logic       res;
      logic       drain;
      logic       interior;
      logic       last;
      logic [1:0] slot;
   } ctl_type;

endpackage

// File: rtl/bmf_ram.sv
// generic single-write, single-read ram with registered read data
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old word when the same address is written
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bmf_cell.sv
// one window column cell: five pixels and their sum, shifted to the older neighbor
module bmf_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift,
   input  bmf_pkg::column_type               load_col,
   input  logic [bmf_pkg::COL_SUM_W-1:0]     load_sum,
   output bmf_pkg::column_type               col_out,
   output logic [bmf_pkg::COL_SUM_W-1:0]     sum_out
);
   import bmf_pkg::*;

   column_type             col_ff, col_in;
   logic [COL_SUM_W-1:0]   sum_ff, sum_in;

   // take the newer column on each pushed pixel
   always_comb begin
      col_in = col_ff;
      sum_in = sum_ff;
      if (shift) begin
         col_in = load_col;
         sum_in = load_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         sum_ff <= '0;
      end else begin
         col_ff <= col_in;
         sum_ff <= sum_in;
      end
   end

   assign col_out = col_ff;
   assign sum_out = sum_ff;

endmodule

// File: rtl/bmf_seq.sv
// frame sequencer: config registers, input and output raster counters
module bmf_seq #(
   parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  bmf_pkg::csr_index_type         csr_index,
   input  logic [bmf_pkg::CFG_W-1:0]      csr_data,
   input  logic                           item_accept,
   input  bmf_pkg::op_type                item_op,
   output bmf_pkg::ctl_type               ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]   col_addr
);
   import bmf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int OW = $clog2(MAX_HEIGHT);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [RW-1:0]    in_row_ff, in_row_in;
   logic [CW-1:0]    in_col_ff, in_col_in;
   logic [OW-1:0]    out_row_ff, out_row_in;
   logic [CW-1:0]    out_col_ff, out_col_in;

   logic [WW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic          in_done;
   logic          in_wrap;
   logic          out_wrap;
   logic          started;
   logic          interior;
   logic          is_last;
   logic          push;
   logic          drain;
   logic          emit;

   // effective frame size: zero acts as one, clamp to the maximum
   always_comb begin
      w_eff = WW'(width_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end
      h_eff = RW'(height_ff);
      if (height_ff == '0) begin
         h_eff = RW'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = RW'(MAX_HEIGHT);
      end
   end

   // raster position status
   always_comb begin
      in_done  = in_row_ff >= h_eff;
      in_wrap  = (WW'(in_col_ff) + WW'(1)) >= w_eff;
      out_wrap = (WW'(out_col_ff) + WW'(1)) >= w_eff;
      is_last  = ((RW'(out_row_ff) + RW'(1)) >= h_eff) && out_wrap;
      // output starts two rows plus two pixels behind the input
      if (w_eff == WW'(1)) begin
         started = in_row_ff >= RW'(4);
      end else begin
         started = (in_row_ff >= RW'(3)) ||
                   ((in_row_ff == RW'(2)) && (in_col_ff >= CW'(2)));
      end
      interior = (out_row_ff >= OW'(BOX_HALF)) &&
                 ((RW + 1)'(out_row_ff) + (RW + 1)'(BOX_HALF) < (RW + 1)'(h_eff)) &&
                 (out_col_ff >= CW'(BOX_HALF)) &&
                 ((WW + 1)'(out_col_ff) + (WW + 1)'(BOX_HALF) < (WW + 1)'(w_eff));
   end

   // transfer control to the datapath
   always_comb begin
      drain = item_accept && in_done;
      push  = item_accept && !in_done && (item_op == OP_PIXEL);
      emit  = drain || (push && started);

      ctl          = '0;
      ctl.push     = push;
      ctl.res      = emit;
      ctl.drain    = drain;
      ctl.interior = interior;
      ctl.last     = is_last;
      ctl.slot     = in_done ? out_row_ff[1:0] : in_row_ff[1:0];
      col_addr     = in_done ? out_col_ff : in_col_ff;
   end

   // next counters and registers
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
         endcase
      end

      if (push) begin
         if (in_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end

      // the frame's last result returns every position to the start
      if (emit) begin
         if (is_last) begin
            in_row_in  = '0;
            in_col_in  = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else if (out_wrap) begin
            out_col_in = '0;
            out_row_in = out_row_ff + OW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CFG_RESET;
         height_ff  <= CFG_RESET;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

endmodule

// File: rtl/box_mean_filter_5x5_core.sv
// top level of the streaming 5x5 box mean filter
// Usage:
// - req channel takes one item per transfer: a pixel of the frame in raster order, or a
//   flush that drains one pending result once the frame's last pixel is in.
// - rsp channel gives one result per interior pixel (5x5 mean, rounded down) or the
//   original pixel within two rows or columns of the frame edge; last marks the frame's
//   final result. Results lag two rows plus two pixels behind the input.
// - csr channel writes frame_width (index 0) and frame_height (index 1); csr_ready is
//   always high. Write only while the block is idle.
// - throughput: one item per clock while req_ready holds, set by the four line rams (all
//   read, one written per transfer) and the five column cells that shift once per pixel.
// - pipeline: a result passes the ram read, cell shift, box sum, reciprocal multiply and
//   result queue registers before it shows on rsp_valid.
// - an 8-entry result queue parts the two sides; req_ready drops only when queued plus
//   in-flight results would fill it, so a stalled receiver stops input after a few items.
// - reset clears counters, window cells, pipeline and queue and sets both sizes to 256;
//   the line rams are not cleared and need no clearing pass.
module box_mean_filter_5x5_core #(
   parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bmf_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bmf_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  bmf_pkg::csr_index_type       csr_index,
   input  logic [bmf_pkg::CFG_W-1:0]    csr_data
);
   import bmf_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int OCC_W = FIFO_CW + 1;

   logic                                req_accept;
   logic                                csr_write;
   ctl_type                             s0_ctl;
   logic [CW-1:0]                       col_addr;
   logic [LINE_ROWS-1:0]                ram_we;
   logic [LINE_ROWS-1:0][PIX_W-1:0]     ram_rdata;

   ctl_type                             ctl1_ff, ctl1_in;
   logic [PIX_W-1:0]                    pix1_ff, pix1_in;
   column_type                          new_col;
   logic [COL_SUM_W-1:0]                new_sum;
   column_type                          cell_col [BOX_N];
   logic [COL_SUM_W-1:0]                cell_sum [BOX_N];

   logic                                res2_ff, res2_in;
   logic                                drain2_ff, drain2_in;
   logic                                int2_ff, int2_in;
   logic                                last2_ff, last2_in;
   logic [PIX_W-1:0]                    dval2_ff, dval2_in;
   logic [BOX_SUM_W-1:0]                box_sum;

   logic                                res3_ff, res3_in;
   logic                                int3_ff, int3_in;
   logic                                last3_ff, last3_in;
   logic [BOX_SUM_W-1:0]                sum3_ff, sum3_in;
   logic [PIX_W-1:0]                    center3_ff, center3_in;

   logic                                res4_ff, res4_in;
   logic                                int4_ff, int4_in;
   logic                                last4_ff, last4_in;
   logic [PROD_W-1:0]                   prod4_ff, prod4_in;
   logic [PIX_W-1:0]                    center4_ff, center4_in;

   rsp_type                             fifo_mem_ff [FIFO_DEPTH];
   rsp_type                             fifo_wdata;
   logic [FIFO_AW-1:0]                  head_ff, head_in;
   logic [FIFO_AW-1:0]                  tail_ff, tail_in;
   logic [FIFO_CW-1:0]                  count_ff, count_in;
   logic                                fifo_push;
   logic                                fifo_pop;
   logic [OCC_W-1:0]                    occupancy;

   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // raster counters and transfer control
   bmf_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .item_accept (req_accept),
      .item_op     (req_data.op),
      .ctl         (s0_ctl),
      .col_addr    (col_addr)
   );

   // four line rams, one per row slot; the slot of the current row is written
   for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
      assign ram_we[k] = s0_ctl.push && (s0_ctl.slot == 2'(k));

      bmf_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock (clock),
         .we    (ram_we[k]),
         .waddr (col_addr),
         .wdata (req_data.pixel),
         .re    (req_accept),
         .raddr (col_addr),
         .rdata (ram_rdata[k])
      );
   end

   // stage 1: ram data arrives, build the new column oldest row first
   assign ctl1_in = s0_ctl;
   assign pix1_in = req_data.pixel;

   always_comb begin
      new_col = '0;
      new_sum = '0;
      for (int r = 0; r < LINE_ROWS; r++) begin
         new_col[r] = ram_rdata[2'(ctl1_ff.slot + 2'(r))];
      end
      new_col[BOX_N-1] = pix1_ff;
      for (int r = 0; r < BOX_N; r++) begin
         new_sum = new_sum + COL_SUM_W'(new_col[r]);
      end
   end

   // chain of column cells, the newest column enters at the top cell
   for (genvar c = 0; c < BOX_N; c++) begin : g_cell
      if (c == BOX_N - 1) begin : g_head
         bmf_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ctl1_ff.push),
            .load_col (new_col),
            .load_sum (new_sum),
            .col_out  (cell_col[c]),
            .sum_out  (cell_sum[c])
         );
      end else begin : g_body
         bmf_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ctl1_ff.push),
            .load_col (cell_col[c+1]),
            .load_sum (cell_sum[c+1]),
            .col_out  (cell_col[c]),
            .sum_out  (cell_sum[c])
         );
      end
   end

   // drained results read the stored pixel straight from its row slot
   assign res2_in   = ctl1_ff.res;
   assign drain2_in = ctl1_ff.drain;
   assign int2_in   = ctl1_ff.interior;
   assign last2_in  = ctl1_ff.last;
   assign dval2_in  = ram_rdata[ctl1_ff.slot];

   // stage 2: box sum over the five column sums, pick the center pixel
   always_comb begin
      box_sum = '0;
      for (int c = 0; c < BOX_N; c++) begin
         box_sum = box_sum + BOX_SUM_W'(cell_sum[c]);
      end
   end

   assign res3_in    = res2_ff;
   assign int3_in    = int2_ff && !drain2_ff;
   assign last3_in   = last2_ff;
   assign sum3_in    = box_sum;
   assign center3_in = drain2_ff ? dval2_ff : cell_col[BOX_HALF][BOX_HALF];

   // stage 3: divide by 25 through the reciprocal
   assign res4_in    = res3_ff;
   assign int4_in    = int3_ff;
   assign last4_in   = last3_ff;
   assign prod4_in   = PROD_W'(sum3_ff) * PROD_W'(DIV_MULT);
   assign center4_in = center3_ff;

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         res2_ff <= 1'b0;
         res3_ff <= 1'b0;
         res4_ff <= 1'b0;
      end else begin
         ctl1_ff <= ctl1_in;
         res2_ff <= res2_in;
         res3_ff <= res3_in;
         res4_ff <= res4_in;
      end
   end

   always_ff @(posedge clock) begin
      pix1_ff    <= pix1_in;
      drain2_ff  <= drain2_in;
      int2_ff    <= int2_in;
      last2_ff   <= last2_in;
      dval2_ff   <= dval2_in;
      int3_ff    <= int3_in;
      last3_ff   <= last3_in;
      sum3_ff    <= sum3_in;
      center3_ff <= center3_in;
      int4_ff    <= int4_in;
      last4_ff   <= last4_in;
      prod4_ff   <= prod4_in;
      center4_ff <= center4_in;
   end

   // stage 4: result into the queue
   always_comb begin
      fifo_wdata.value = int4_ff ? prod4_ff[DIV_SHIFT +: PIX_W] : center4_ff;
      fifo_wdata.last  = last4_ff;
   end

   assign fifo_push = res4_ff;
   assign fifo_pop  = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = fifo_mem_ff[head_ff];

   // queue pointers
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (fifo_push) begin
         tail_in = tail_ff + FIFO_AW'(1);
      end
      if (fifo_pop) begin
         head_in = head_ff + FIFO_AW'(1);
      end
      unique case ({fifo_push, fifo_pop})
         2'b10:   count_in = count_ff + FIFO_CW'(1);
         2'b01:   count_in = count_ff - FIFO_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem_ff[tail_ff] <= fifo_wdata;
      end
   end

   // accept only while every result in flight has a queue entry
   assign occupancy = OCC_W'(count_ff) + OCC_W'(ctl1_ff.res) + OCC_W'(res2_ff) +
                      OCC_W'(res3_ff) + OCC_W'(res4_ff);
   assign req_ready = occupancy < OCC_W'(FIFO_DEPTH);

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(FIFO_DEPTH))
      else $error("results in flight exceed the queue");

   a_one_slot_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ram_we))
      else $error("more than one line ram written");

   a_drain_no_shift: assert property (@(posedge clock) disable iff (reset)
      ctl1_ff.drain |-> !ctl1_ff.push && ctl1_ff.res)
      else $error("drain transfer moved the window");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      fifo_push |=> rsp_valid)
      else $error("queued result not offered");
`endif

endmodule
